/* sv/paw_pkg.sv */
package paw_pkg;

	// Field widths of items and registers
	localparam int ADDR_W          = 16;
	localparam int PIXEL_BITS      = 16;
	localparam int COORD_W         = 22;
	localparam int TRI_W           = 24;
	localparam int TRI_AW          = 9;
	localparam int VTX_AW          = 8;
	localparam int WEIGHT_W        = 18;
	localparam int DIM_W           = 11;
	localparam int COORD_FRAC_BITS = 8;
	localparam int WEIGHT_FRAC_BITS = 16;
	localparam int BLEND_FRAC      = 16;

	// Derived arithmetic widths
	localparam int FB      = COORD_FRAC_BITS + WEIGHT_FRAC_BITS;
	localparam int VD_W    = COORD_W + 1;
	localparam int PROD_W  = VD_W + WEIGHT_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int INT_W   = SUM_W - FB;
	localparam int ROWP_W  = INT_W + DIM_W + 1;
	localparam int IDX_W   = ROWP_W + 1;
	localparam int LIM_W   = 2 * DIM_W;
	localparam int OM_W    = BLEND_FRAC + 1;
	localparam int WT_W    = 2 * OM_W;
	localparam int MUL_W   = WT_W + PIXEL_BITS;
	localparam int ACC_W   = MUL_W + 2;
	localparam int VTX_W   = 2 * COORD_W;

	// Stream packing
	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [1:0] {
		OP_IMAGE = 2'd0,
		OP_VERTEX = 2'd1,
		OP_TRIANGLE = 2'd2,
		OP_WARP = 2'd3
	} op_t;

	typedef enum logic {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	// Per-item control that travels with every stage
	typedef struct packed {
		logic                  valid;
		op_t                   op;
		logic [ADDR_W-1:0]     addr;
		logic [PIXEL_BITS-1:0] pix;
		logic                  last;
	} ctl_t;

endpackage

/* sv/paw_geom_mem.sv */
module paw_geom_mem (
	input  logic                             clk,
	input  logic                             adv,
	input  logic                             tri_we,
	input  logic [paw_pkg::TRI_AW-1:0]       tri_waddr,
	input  logic [paw_pkg::TRI_W-1:0]        tri_wdata,
	input  logic [paw_pkg::TRI_AW-1:0]       tri_raddr,
	output logic [paw_pkg::TRI_W-1:0]        tri_rdata,
	input  logic                             vtx_we,
	input  logic [paw_pkg::VTX_AW-1:0]       vtx_waddr,
	input  logic [paw_pkg::VTX_W-1:0]        vtx_wdata,
	input  logic [2:0][paw_pkg::VTX_AW-1:0]  vtx_raddr,
	output logic [2:0][paw_pkg::VTX_W-1:0]   vtx_rdata
);
	import paw_pkg::*;

	localparam int TRI_DEPTH = 1 << TRI_AW;
	localparam int VTX_DEPTH = 1 << VTX_AW;

	logic [TRI_W-1:0] tri_mem [TRI_DEPTH];

	// Triangle table: one write and one read port, read held on stall
	always_ff @(posedge clk) begin
		if (tri_we)
			tri_mem[tri_waddr] <= tri_wdata;
		if (adv)
			tri_rdata <= tri_mem[tri_raddr];
	end

	// Vertex table: one copy per triangle corner, all written alike
	for (genvar c = 0; c < 3; c++) begin : g_vtx
		logic [VTX_W-1:0] vtx_mem [VTX_DEPTH];
		always_ff @(posedge clk) begin
			if (vtx_we)
				vtx_mem[vtx_waddr] <= vtx_wdata;
			if (adv)
				vtx_rdata[c] <= vtx_mem[vtx_raddr[c]];
		end
	end

endmodule

/* sv/paw_image_mem.sv */
module paw_image_mem (
	input  logic                                 clk,
	input  logic                                 adv,
	input  logic                                 we,
	input  logic [paw_pkg::ADDR_W-1:0]           waddr,
	input  logic [paw_pkg::PIXEL_BITS-1:0]       wdata,
	input  logic [3:0][paw_pkg::ADDR_W-1:0]      raddr,
	output logic [3:0][paw_pkg::PIXEL_BITS-1:0]  rdata
);
	import paw_pkg::*;

	localparam int DEPTH = 1 << ADDR_W;

	// Four copies, one per bilinear neighbour, written together
	for (genvar b = 0; b < 4; b++) begin : g_copy
		logic [PIXEL_BITS-1:0] mem [DEPTH];
		always_ff @(posedge clk) begin
			if (we)
				mem[waddr] <= wdata;
			if (adv)
				rdata[b] <= mem[raddr[b]];
		end
	end

endmodule

/* sv/piecewise_affine_bilinear_warp.sv */
// Channel   Dir  Payload
// s_axis    in   tdata: address, pixel_value, coord_x, coord_y, tri_vertices,
//                triangle_index, weight_alpha, weight_beta, weight_gamma;
//                tuser: operation; tlast: final_pixel
// m_axis    out  tdata: dest_index, warped_value; tuser: written; tlast: frame_done
// cfg       in   cfg_we, cfg_index (0 rows, 1 cols), cfg_data
//
// One item per cycle while the output is not stalled. A warp item passes these stages in
// order once it is accepted: triangle read, vertex read, blend multiply, blend sum, row
// multiply, index and weight, image read, sample multiply, output register.
// Loads write each store at the stage where warp items read it, so the
// stream order holds with no forwarding. Stores need no clearing after reset.
// A stalled output freezes the whole pipeline, memory read registers included.
module piecewise_affine_bilinear_warp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// address, pixel_value, coord_x, coord_y, tri_vertices, triangle_index,
	// weight_alpha, weight_beta, weight_gamma, zero fill
	input  logic [paw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [1:0]                     s_axis_tuser,   // operation
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [paw_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // dest_index, warped_value
	output logic                           m_axis_tuser,   // written
	output logic                           m_axis_tlast,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [paw_pkg::DIM_W-1:0]      cfg_data
);
	import paw_pkg::*;

	logic adv;
	logic [DIM_W-1:0] rows_q, cols_q;
	logic [LIM_W-1:0] lim_q;
	ctl_t ctl_in;
	ctl_t pipe_s [1:8];

	logic signed [COORD_W-1:0]  cx_in, cy_in;
	logic signed [WEIGHT_W-1:0] wa_in, wb_in, wg_in;

	logic signed [COORD_W-1:0]  cx_s1, cy_s1;
	logic signed [WEIGHT_W-1:0] wa_s1, wb_s1, wg_s1, wa_s2, wb_s2, wg_s2;
	logic [TRI_W-1:0]           tri_s1;
	logic [2:0][VTX_AW-1:0]     vaddr;
	logic [2:0][VTX_W-1:0]      vtx_s2;
	logic signed [PROD_W-1:0]   px_s3 [3];
	logic signed [PROD_W-1:0]   py_s3 [3];
	logic signed [SUM_W-1:0]    tx_s4, ty_s4;
	logic signed [ROWP_W-1:0]   rp_s5;
	logic signed [INT_W-1:0]    fy_s5;
	logic [BLEND_FRAC-1:0]      dx_s5, dy_s5;
	logic signed [IDX_W-1:0]    idx_s6 [4];
	logic [WT_W-1:0]            wt_s6 [4];
	logic [WT_W-1:0]            wt_s7 [4];
	logic                       ok_s7;
	logic [3:0][ADDR_W-1:0]     iaddr;
	logic [3:0][PIXEL_BITS-1:0] pix_s7;
	logic [MUL_W-1:0]           mul_s8 [4];
	logic                       ok_s8;
	logic [ACC_W-1:0]           acc;
	logic signed [IDX_W-1:0]    base_idx, rows_idx;
	logic [OM_W-1:0]            omdx, omdy, dx_e, dy_e;
	logic                       in_range;

	// Unpack the input item
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign ctl_in.valid = s_axis_tvalid;
	assign ctl_in.op    = op_t'(s_axis_tuser);
	assign ctl_in.addr  = s_axis_tdata[15:0];
	assign ctl_in.pix   = s_axis_tdata[31:16];
	assign ctl_in.last  = s_axis_tlast;
	assign cx_in = s_axis_tdata[53:32];
	assign cy_in = s_axis_tdata[75:54];
	assign wa_in = s_axis_tdata[126:109];
	assign wb_in = s_axis_tdata[144:127];
	assign wg_in = s_axis_tdata[162:145];

	// Configuration registers and the address bound
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_W'(256);
			cols_q <= DIM_W'(256);
			lim_q  <= LIM_W'(65536);
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_ROWS: rows_q <= cfg_data;
					REG_COLS: cols_q <= cfg_data;
					default: ;
				endcase
			end
			lim_q <= rows_q * cols_q;
		end
	end

	// Advance the per-item control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= 8; i++)
				pipe_s[i] <= '0;
		end else if (adv) begin
			pipe_s[1] <= ctl_in;
			for (int i = 2; i <= 8; i++)
				pipe_s[i] <= pipe_s[i-1];
		end
	end

	// Triangle and vertex stores
	for (genvar c = 0; c < 3; c++) begin : g_vaddr
		assign vaddr[c] = tri_s1[8*c +: VTX_AW];
	end

	paw_geom_mem u_geom (
		.clk       (clk),
		.adv       (adv),
		.tri_we    (adv && s_axis_tvalid && ctl_in.op == OP_TRIANGLE),
		.tri_waddr (ctl_in.addr[TRI_AW-1:0]),
		.tri_wdata (s_axis_tdata[99:76]),
		.tri_raddr (s_axis_tdata[108:100]),
		.tri_rdata (tri_s1),
		.vtx_we    (adv && pipe_s[1].valid && pipe_s[1].op == OP_VERTEX),
		.vtx_waddr (pipe_s[1].addr[VTX_AW-1:0]),
		.vtx_wdata ({cy_s1, cx_s1}),
		.vtx_raddr (vaddr),
		.vtx_rdata (vtx_s2)
	);

	// Index and weight terms of the current stage
	assign base_idx = IDX_W'(fy_s5) + IDX_W'(rp_s5);
	assign rows_idx = IDX_W'(signed'({1'b0, rows_q}));
	assign dx_e = {1'b0, dx_s5};
	assign dy_e = {1'b0, dy_s5};
	assign omdx = OM_W'(1 << BLEND_FRAC) - dx_e;
	assign omdy = OM_W'(1 << BLEND_FRAC) - dy_e;

	always_comb begin
		in_range = 1'b1;
		for (int k = 0; k < 4; k++)
			if (idx_s6[k] < 0 || idx_s6[k] >= IDX_W'(signed'({1'b0, lim_q})))
				in_range = 1'b0;
	end

	// Datapath registers, held while the output is stalled
	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s1 <= cx_in;
			cy_s1 <= cy_in;
			wa_s1 <= wa_in;
			wb_s1 <= wb_in;
			wg_s1 <= wg_in;
			wa_s2 <= wa_s1;
			wb_s2 <= wb_s1;
			wg_s2 <= wg_s1;
			// blend: (v - 1.0) * weight for each corner
			for (int c = 0; c < 3; c++) begin
				automatic logic signed [VD_W-1:0] vx, vy;
				automatic logic signed [WEIGHT_W-1:0] w;
				vx = VD_W'(signed'(vtx_s2[c][COORD_W-1:0])) - VD_W'(1 << COORD_FRAC_BITS);
				vy = VD_W'(signed'(vtx_s2[c][VTX_W-1:COORD_W])) - VD_W'(1 << COORD_FRAC_BITS);
				w = (c == 0) ? wg_s2 : (c == 1) ? wa_s2 : wb_s2;
				px_s3[c] <= vx * w;
				py_s3[c] <= vy * w;
			end
			tx_s4 <= SUM_W'(px_s3[0]) + SUM_W'(px_s3[1]) + SUM_W'(px_s3[2]);
			ty_s4 <= SUM_W'(py_s3[0]) + SUM_W'(py_s3[1]) + SUM_W'(py_s3[2]);
			// floor and 16-bit fraction, then column offset
			rp_s5 <= signed'(tx_s4[SUM_W-1:FB]) * signed'({1'b0, rows_q});
			fy_s5 <= ty_s4[SUM_W-1:FB];
			dx_s5 <= tx_s4[FB-1:FB-BLEND_FRAC];
			dy_s5 <= ty_s4[FB-1:FB-BLEND_FRAC];
			// four neighbour indices and bilinear weights
			idx_s6[0] <= base_idx;
			idx_s6[1] <= base_idx + rows_idx;
			idx_s6[2] <= base_idx + IDX_W'(1);
			idx_s6[3] <= base_idx + rows_idx + IDX_W'(1);
			wt_s6[0] <= omdx * omdy;
			wt_s6[1] <= dx_e * omdy;
			wt_s6[2] <= omdx * dy_e;
			wt_s6[3] <= dx_e * dy_e;
			ok_s7 <= in_range;
			for (int k = 0; k < 4; k++) begin
				wt_s7[k] <= wt_s6[k];
				mul_s8[k] <= wt_s7[k] * pix_s7[k];
			end
			ok_s8 <= ok_s7;
		end
	end

	// Image store, written at the stage where it is read
	for (genvar k = 0; k < 4; k++) begin : g_iaddr
		assign iaddr[k] = idx_s6[k][ADDR_W-1:0];
	end

	paw_image_mem u_image (
		.clk   (clk),
		.adv   (adv),
		.we    (adv && pipe_s[6].valid && pipe_s[6].op == OP_IMAGE),
		.waddr (pipe_s[6].addr),
		.wdata (pipe_s[6].pix),
		.raddr (iaddr),
		.rdata (pix_s7)
	);

	assign acc = ACC_W'(mul_s8[0]) + ACC_W'(mul_s8[1]) + ACC_W'(mul_s8[2])
		+ ACC_W'(mul_s8[3]);

	// Output register: drop load items, hold on stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= pipe_s[8].valid && pipe_s[8].op == OP_WARP;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {ok_s8 ? acc[2*BLEND_FRAC +: PIXEL_BITS] : '0, pipe_s[8].addr};
			m_axis_tuser <= ok_s8;
			m_axis_tlast <= pipe_s[8].last;
		end
	end

	// A rejected sample carries value zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:16] == '0)
		else $error("unwritten sample with nonzero value");

	// A warp item at the last stage reaches the output when the pipe moves
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && pipe_s[8].valid && pipe_s[8].op == OP_WARP |=> m_axis_tvalid)
		else $error("warp item lost at output");

	// A load item never produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && pipe_s[8].valid && pipe_s[8].op != OP_WARP |=> !m_axis_tvalid)
		else $error("load item produced a result");

endmodule

/* dv/piecewise_affine_bilinear_warp_tb.sv */
`timescale 1ns / 1ps

module piecewise_affine_bilinear_warp_tb;
	import paw_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int SETTLE = 20;

	typedef struct {
		op_t                    op;
		logic [15:0]            addr;
		logic [15:0]            pix;
		logic signed [21:0]     cx;
		logic signed [21:0]     cy;
		logic [23:0]            verts;
		logic [8:0]             tri_sel;
		logic signed [17:0]     wa;
		logic signed [17:0]     wb;
		logic signed [17:0]     wg;
		logic                   last;
		bit                     fixed;
		logic [15:0]            fixed_val;
		logic                   fixed_wr;
	} paw_item_t;

	typedef struct {
		logic [15:0] dest;
		logic [15:0] value;
		logic        wr;
		logic        done;
	} warp_pixel_t;

	typedef struct {
		bit     ok;
		longint idx [4];
		longint dx;
		longint dy;
	} sample_point_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // address, pixel_value, coord_x, coord_y,
	                                       // tri_vertices, triangle_index, weight_alpha,
	                                       // weight_beta, weight_gamma, zero fill
	logic [1:0]            s_axis_tuser;   // operation
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // dest_index, warped_value
	logic                  m_axis_tuser;   // written
	logic                  m_axis_tlast;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [DIM_W-1:0]      cfg_data;

	piecewise_affine_bilinear_warp uut (.*);

	// Shadow copy of the block state
	logic [15:0]        src_image [65536];
	bit                 src_image_set [65536];
	logic signed [21:0] vert_x [256];
	logic signed [21:0] vert_y [256];
	bit                 vert_set [256];
	logic [23:0]        tri_verts [512];
	bit                 tri_set [512];
	int                 rows;
	int                 cols;

	warp_pixel_t pending_pixels [$];
	int          errors;
	int          items_sent;
	int          pixels_seen;
	int          pixels_written;
	int          frames_seen;
	longint      cycles;
	bit          tx_burst;
	bit          rx_burst;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Locate the source point and its four neighbours
	function automatic sample_point_t locate(logic [8:0] tri_sel, logic signed [17:0] wa,
			logic signed [17:0] wb, logic signed [17:0] wg);
		sample_point_t sp;
		logic [7:0] v0, v1, v2;
		longint tx, ty, fx, fy, lim;
		v0 = tri_verts[tri_sel][7:0];
		v1 = tri_verts[tri_sel][15:8];
		v2 = tri_verts[tri_sel][23:16];
		tx = (longint'(vert_x[v0]) - 256) * longint'(wg) + (longint'(vert_x[v1]) - 256)
			* longint'(wa) + (longint'(vert_x[v2]) - 256) * longint'(wb);
		ty = (longint'(vert_y[v0]) - 256) * longint'(wg) + (longint'(vert_y[v1]) - 256)
			* longint'(wa) + (longint'(vert_y[v2]) - 256) * longint'(wb);
		fx = tx >>> FB;
		fy = ty >>> FB;
		sp.dx = (tx >> (FB - BLEND_FRAC)) & 64'hFFFF;
		sp.dy = (ty >> (FB - BLEND_FRAC)) & 64'hFFFF;
		sp.idx[0] = fy + fx * rows;
		sp.idx[1] = fy + (fx + 1) * rows;
		sp.idx[2] = fy + 1 + fx * rows;
		sp.idx[3] = fy + 1 + (fx + 1) * rows;
		lim = longint'(rows) * cols;
		sp.ok = 1'b1;
		for (int k = 0; k < 4; k++)
			if (sp.idx[k] < 0 || sp.idx[k] >= lim)
				sp.ok = 1'b0;
		return sp;
	endfunction

	// Bilinear blend of the four neighbours, truncated
	function automatic logic [15:0] interpolate(sample_point_t sp);
		longint unsigned one, acc;
		longint unsigned wt [4];
		one = 64'd1 << BLEND_FRAC;
		wt[0] = (one - sp.dx) * (one - sp.dy);
		wt[1] = sp.dx * (one - sp.dy);
		wt[2] = (one - sp.dx) * sp.dy;
		wt[3] = sp.dx * sp.dy;
		acc = 0;
		for (int k = 0; k < 4; k++)
			acc += wt[k] * longint'(src_image[sp.idx[k][15:0]]);
		return acc[47:32];
	endfunction

	function automatic logic signed [21:0] coord_near(int span);
		return 22'($urandom_range(0, (span + 1) * 256));
	endfunction

	function automatic paw_item_t blank_item(op_t op);
		paw_item_t it;
		it.op = op;
		it.addr = 16'($urandom);
		it.pix = 16'($urandom);
		it.cx = 22'($urandom);
		it.cy = 22'($urandom);
		it.verts = 24'($urandom);
		it.tri_sel = 9'($urandom);
		it.wa = 18'($urandom);
		it.wb = 18'($urandom);
		it.wg = 18'($urandom);
		it.last = ($urandom_range(0, 15) == 0);
		it.fixed = 1'b0;
		it.fixed_val = '0;
		it.fixed_wr = 1'b0;
		return it;
	endfunction

	// Put one item on the input stream and wait for its handshake
	task automatic push_item(paw_item_t it);
		int gap;
		if ($urandom_range(0, 49) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 19);
		repeat (gap) @(negedge clk) s_axis_tvalid <= 1'b0;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, it.wg, it.wb, it.wa, it.tri_sel, it.verts, it.cy, it.cx,
			it.pix, it.addr};
		s_axis_tuser <= it.op;
		s_axis_tlast <= it.last;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Update the shadow state, fill anything a warp would read unset, queue the result
	task automatic issue(paw_item_t it);
		paw_item_t fill;
		sample_point_t sp;
		warp_pixel_t px;
		logic [7:0] vi;
		case (it.op)
			OP_IMAGE: begin
				src_image[it.addr] = it.pix;
				src_image_set[it.addr] = 1'b1;
			end
			OP_VERTEX: begin
				vert_x[it.addr[7:0]] = it.cx;
				vert_y[it.addr[7:0]] = it.cy;
				vert_set[it.addr[7:0]] = 1'b1;
			end
			OP_TRIANGLE: begin
				tri_verts[it.addr[8:0]] = it.verts;
				tri_set[it.addr[8:0]] = 1'b1;
			end
			default: begin
				if (!tri_set[it.tri_sel]) begin
					fill = blank_item(OP_TRIANGLE);
					fill.addr = {7'd0, it.tri_sel};
					fill.verts = {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
						8'($urandom_range(0, 15))};
					issue(fill);
				end
				for (int k = 0; k < 3; k++) begin
					vi = tri_verts[it.tri_sel][8*k +: 8];
					if (!vert_set[vi]) begin
						fill = blank_item(OP_VERTEX);
						fill.addr = {8'd0, vi};
						fill.cx = coord_near(cols);
						fill.cy = coord_near(rows);
						issue(fill);
					end
				end
				sp = locate(it.tri_sel, it.wa, it.wb, it.wg);
				if (sp.ok)
					for (int k = 0; k < 4; k++)
						if (!src_image_set[sp.idx[k][15:0]]) begin
							fill = blank_item(OP_IMAGE);
							fill.addr = sp.idx[k][15:0];
							issue(fill);
						end
				px.dest = it.addr;
				px.done = it.last;
				if (it.fixed) begin
					px.value = it.fixed_val;
					px.wr = it.fixed_wr;
				end else begin
					px.wr = sp.ok;
					px.value = sp.ok ? interpolate(sp) : 16'd0;
				end
				pending_pixels.push_back(px);
			end
		endcase
		push_item(it);
	endtask

	// Random item: mostly shaped warps and loads, some noise
	function automatic paw_item_t random_item();
		paw_item_t it;
		int r;
		int a;
		int b;
		int lim;
		r = $urandom_range(0, 99);
		lim = rows * cols;
		if (r < 8) begin
			it = blank_item(op_t'($urandom_range(0, 3)));
		end else if (r < 16) begin
			it = blank_item(OP_VERTEX);
			it.addr[7:0] = 8'($urandom_range(0, 15));
			it.cx = coord_near(cols);
			it.cy = coord_near(rows);
		end else if (r < 21) begin
			it = blank_item(OP_TRIANGLE);
			it.addr[8:0] = 9'($urandom_range(0, 31));
			it.verts = {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
				8'($urandom_range(0, 15))};
		end else if (r < 27) begin
			it = blank_item(OP_IMAGE);
			if (lim > 0 && lim <= 65536)
				it.addr = 16'($urandom_range(0, lim - 1));
		end else begin
			it = blank_item(OP_WARP);
			it.tri_sel = 9'($urandom_range(0, 31));
			a = $urandom_range(0, 65536);
			b = $urandom_range(0, 65536 - a);
			it.wa = 18'(a);
			it.wb = 18'(b);
			it.wg = 18'(65536 - a - b);
		end
		return it;
	endfunction

	task automatic drain_pipeline();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DIM_W'(value);
		@(negedge clk) cfg_we <= 1'b0;
		if (idx == REG_ROWS)
			rows = value;
		else
			cols = value;
	endtask

	// Result side: random stalls, one long hold-off, check against the oldest pixel
	initial begin
		warp_pixel_t want;
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 49) == 0)
				rx_burst = !rx_burst;
			gap = rx_burst ? 0 : $urandom_range(0, 19);
			if (pixels_seen == 200)
				gap = 400;
			repeat (gap) @(negedge clk) m_axis_tready <= 1'b0;
			@(negedge clk) m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			pixels_seen++;
			if (m_axis_tuser)
				pixels_written++;
			if (m_axis_tlast)
				frames_seen++;
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t: unexpected pixel, got dest %h value %h written %b done %b",
					$realtime, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser,
					m_axis_tlast);
			end else begin
				want = pending_pixels.pop_front();
				if (m_axis_tdata[15:0] !== want.dest) begin
					errors++;
					$display("%0t: dest_index expected %h got %h", $realtime, want.dest,
						m_axis_tdata[15:0]);
				end
				if (m_axis_tdata[31:16] !== want.value) begin
					errors++;
					$display("%0t: warped_value expected %h got %h (dest %h)", $realtime,
						want.value, m_axis_tdata[31:16], want.dest);
				end
				if (m_axis_tuser !== want.wr) begin
					errors++;
					$display("%0t: written expected %b got %b (dest %h)", $realtime,
						want.wr, m_axis_tuser, want.dest);
				end
				if (m_axis_tlast !== want.done) begin
					errors++;
					$display("%0t: frame_done expected %b got %b (dest %h)", $realtime,
						want.done, m_axis_tlast, want.dest);
				end
			end
		end
	end

	// Directed rows, then random phases over several image sizes
	initial begin
		paw_item_t directed [$];
		paw_item_t it;
		int dims [8][2];

		dims = '{'{256, 256}, '{16, 16}, '{1, 1}, '{1024, 1024}, '{0, 9}, '{2047, 2047},
			'{5, 40}, '{33, 7}};
		items_sent = 0;
		tx_burst = 1'b0;
		rows = 256;
		cols = 256;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_IMAGE;
		s_axis_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Image corners and value extremes
		it = blank_item(OP_IMAGE); it.addr = 16'd0;     it.pix = 16'hFFFF; directed.push_back(it);
		it = blank_item(OP_IMAGE); it.addr = 16'd1;     it.pix = 16'h0000; directed.push_back(it);
		it = blank_item(OP_IMAGE); it.addr = 16'd256;   it.pix = 16'h1234; directed.push_back(it);
		it = blank_item(OP_IMAGE); it.addr = 16'd257;   it.pix = 16'h8000; directed.push_back(it);
		it = blank_item(OP_IMAGE); it.addr = 16'hFFFF;  it.pix = 16'h5555; directed.push_back(it);
		// Vertices at (1,1), (2,1), (1,2), coordinate extremes, wrapped index
		it = blank_item(OP_VERTEX); it.addr = 16'd0; it.cx = 22'sd256; it.cy = 22'sd256;
		directed.push_back(it);
		it = blank_item(OP_VERTEX); it.addr = 16'd1; it.cx = 22'sd512; it.cy = 22'sd256;
		directed.push_back(it);
		it = blank_item(OP_VERTEX); it.addr = 16'd2; it.cx = 22'sd256; it.cy = 22'sd512;
		directed.push_back(it);
		it = blank_item(OP_VERTEX); it.addr = 16'd255; it.cx = -22'sd2097152;
		it.cy = 22'sd2097151; directed.push_back(it);
		it = blank_item(OP_VERTEX); it.addr = 16'd259; it.cx = 22'sd2097151;
		it.cy = -22'sd2097152; directed.push_back(it);
		// Triangles, one stored through a wrapped index
		it = blank_item(OP_TRIANGLE); it.addr = 16'd0;   it.verts = 24'h020100;
		directed.push_back(it);
		it = blank_item(OP_TRIANGLE); it.addr = 16'd511; it.verts = 24'hFF0300;
		directed.push_back(it);
		it = blank_item(OP_TRIANGLE); it.addr = 16'd513; it.verts = 24'h000000;
		directed.push_back(it);
		// Warp exactly onto the first vertex: the corner sample itself
		it = blank_item(OP_WARP); it.addr = 16'd0; it.tri_sel = 9'd0; it.wg = 18'sd65536;
		it.wa = '0; it.wb = '0; it.last = 1'b0; it.fixed = 1'b1; it.fixed_val = 16'hFFFF;
		it.fixed_wr = 1'b1; directed.push_back(it);
		it = blank_item(OP_WARP); it.addr = 16'hFFFF; it.tri_sel = 9'd1; it.wg = 18'sd65536;
		it.wa = '0; it.wb = '0; it.last = 1'b1; it.fixed = 1'b1; it.fixed_val = 16'hFFFF;
		it.fixed_wr = 1'b1; directed.push_back(it);
		// Far off the image: emitted as not written
		it = blank_item(OP_WARP); it.addr = 16'd7; it.tri_sel = 9'd511; it.wg = '0;
		it.wa = '0; it.wb = 18'sd65536; it.fixed = 1'b1; it.fixed_val = 16'd0;
		it.fixed_wr = 1'b0; directed.push_back(it);
		// Half pixel step, weight extremes, all-zero weights
		it = blank_item(OP_WARP); it.tri_sel = 9'd0; it.wg = 18'sd32768; it.wa = 18'sd32768;
		it.wb = '0; directed.push_back(it);
		it = blank_item(OP_WARP); it.tri_sel = 9'd0; it.wg = 18'sd16384; it.wa = 18'sd16384;
		it.wb = 18'sd32768; directed.push_back(it);
		it = blank_item(OP_WARP); it.tri_sel = 9'd511; it.wg = '0; it.wa = 18'sd131071;
		it.wb = -18'sd131072; directed.push_back(it);
		it = blank_item(OP_WARP); it.tri_sel = 9'd511; it.wg = -18'sd131072;
		it.wa = 18'sd131071; it.wb = 18'sd131071; directed.push_back(it);
		it = blank_item(OP_WARP); it.tri_sel = 9'd0; it.wg = '0; it.wa = '0; it.wb = '0;
		directed.push_back(it);

		foreach (directed[i])
			issue(directed[i]);

		for (int p = 1; p < 8; p++) begin
			// Reconfigure only with the pipeline empty
			drain_pipeline();
			write_reg(REG_ROWS, dims[p][0]);
			write_reg(REG_COLS, dims[p][1]);
			while (items_sent < p * RANDOM_ITEMS / 7)
				issue(random_item());
		end

		drain_pipeline();
		$display("Sent %0d items over 8 image sizes; %0d pixels checked, %0d written, %0d frames.",
			items_sent, pixels_seen, pixels_written, frames_seen);
		$display("Mismatches: %0d", errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
